// File: sv/appe_pkg.sv
// Package for the adaptive phase progress estimator.
// Holds the item structs, field widths, register indexes and reset values.
// No dependencies; every other file imports it.
package appe_pkg;

  localparam int DUR_W      = 16;
  localparam int PROG_W     = 17;
  localparam int TS_W       = 32;
  localparam int ELAP_W     = 24;
  localparam int LR_W       = 9;
  localparam int PC_W       = 5;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT   = 2'd1;

  localparam logic [LR_W-1:0] LR_RESET = 9'd26;
  localparam logic [PC_W-1:0] PC_RESET = 5'd4;

  localparam logic [ELAP_W-1:0] ELAP_MAX = {ELAP_W{1'b1}};

  // input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TS_W-1:0]   timestamp_ms;
    logic              advance_phase;
    logic [IDX_W-1:0]  load_index;
    logic [DUR_W-1:0]  load_duration;
  } appe_in_t;

  typedef struct packed {
    logic [PROG_W-1:0] progress;
    logic [IDX_W-1:0]  phase_index;
    logic              advanced;
    logic              total_zero;
  } appe_out_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } appe_div_st_t;

endpackage

// File: sv/appe_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on appe_pkg for the payload structs.
interface appe_in_if import appe_pkg::*; ();
  logic     valid;
  logic     ready;
  appe_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface appe_out_if import appe_pkg::*; ();
  logic      valid;
  logic      ready;
  appe_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/appe_tbl.sv
// Duration table: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as zero. Depends on appe_pkg.
module appe_tbl import appe_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [DUR_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [DUR_W-1:0] rd_data
);

  logic [DUR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DUR_W-1:0] dat_q;
  logic             vld_q;

  // write and registered read of the array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    dat_q <= mem[rd_addr];
  end

  // track written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? dat_q : '0;

endmodule

// File: sv/appe_div.sv
// Serial restoring divider: one quotient bit per cycle, PROG_W bits in all.
// Expects numer <= denom, so the quotient fits in PROG_W bits. Depends on appe_pkg.
module appe_div import appe_pkg::*; #(
  parameter int W = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [W-1:0]      numer,
  input  logic [W-1:0]      denom,
  output logic [PROG_W-1:0] quot,
  output appe_div_st_t      st
);

  localparam int CNT_W = $clog2(PROG_W + 1);

  logic [W:0]       rem;
  logic [W:0]       cand;
  logic             ge;
  logic             first;
  logic [CNT_W-1:0] cnt;

  // first step compares the numerator itself, later steps shift in a zero
  assign cand = first ? rem : {rem[W-1:0], 1'b0};
  assign ge   = cand >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      // flag the cycle after the last quotient step
      st.done <= !start && st.busy && (cnt == CNT_W'(1));
      if (start) begin
        rem     <= {1'b0, numer};
        quot    <= '0;
        first   <= 1'b1;
        cnt     <= CNT_W'(PROG_W);
        st.busy <= 1'b1;
      end else if (st.busy) begin
        rem   <= ge ? (cand - {1'b0, denom}) : cand;
        quot  <= {quot[PROG_W-2:0], ge};
        first <= 1'b0;
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          st.busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/adaptive_phase_progress_estimator.sv
// Top level of the adaptive phase progress estimator: sequencer, state and tables.
// Depends on appe_pkg, appe_if, appe_tbl and appe_div.
//
// A load item is taken while idle and writes one entry of both duration tables.
// A sample item runs through a sequencer: it updates the phase time, walks the
// current table once, one table read per cycle, to form the cycle total and the sum
// of earlier phases, then, unless the total is zero, feeds the serial divider, which
// yields one progress bit per cycle. With the advance flag set, one multiply and one
// saturating add correct the next table; when the phase wraps to zero the next table
// is copied into the current one entry by entry. Input ready is held low until the
// result has moved into the output register, which holds one item.
module adaptive_phase_progress_estimator import appe_pkg::*; #(
  parameter int MAX_PHASES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  appe_in_if.sink               in_ch,
  appe_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int CW = $clog2(MAX_PHASES + 1);
  localparam int SW = DUR_W + AW;
  localparam int MW = ELAP_W + LR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TIME = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CORR = 3'd5;
  localparam logic [2:0] S_COPY = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]          state;
  logic [LR_W-1:0]     lr;
  logic [PC_W-1:0]     pc;
  logic [AW-1:0]       active;
  logic [ELAP_W-1:0]   elapsed;
  logic [TS_W-1:0]     prev;
  logic                awaiting;
  logic [TS_W-1:0]     ts_q;
  logic                adv_q;
  logic [CW-1:0]       cnt_eff;
  logic [CW-1:0]       idx;
  logic                rd_v;
  logic [AW-1:0]       rd_i;
  logic [SW-1:0]       total;
  logic [SW-1:0]       earlier;
  logic [DUR_W-1:0]    cur_act;
  logic [PROG_W-1:0]   prog;
  logic                zero_q;
  logic [MW-1:0]       prod;
  logic                neg;
  logic                ovalid;
  appe_out_t           odata;

  logic                in_fire;
  logic                load_ok;
  logic [CW-1:0]       pc_eff;
  logic [TS_W-1:0]     delta;
  logic [TS_W:0]       elap_sum;
  logic [DUR_W-1:0]    capped;
  logic [SW-1:0]       numer;
  logic                err_neg;
  logic [ELAP_W-1:0]   mag;
  logic [MW-9:0]       scaled;
  logic [DUR_W+9:0]    pos_sum;
  logic [DUR_W-1:0]    corr_val;
  logic [AW-1:0]       act_inc;
  logic                sum_last;
  logic                div_start;
  logic [PROG_W-1:0]   quot;
  appe_div_st_t        div_st;

  logic                cur_we;
  logic [AW-1:0]       cur_wa;
  logic [DUR_W-1:0]    cur_wd;
  logic [DUR_W-1:0]    cur_rd;
  logic                nxt_we;
  logic [AW-1:0]       nxt_wa;
  logic [DUR_W-1:0]    nxt_wd;
  logic [AW-1:0]       nxt_ra;
  logic [DUR_W-1:0]    nxt_rd;

  // handshake
  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign load_ok      = in_fire && (in_ch.data.kind == KIND_LOAD) &&
                        (32'(in_ch.data.load_index) < MAX_PHASES);
  assign out_ch.valid = ovalid;
  assign out_ch.data  = odata;

  // clamp the phase count to 1..MAX_PHASES
  always_comb begin
    if (pc == '0) begin
      pc_eff = CW'(1);
    end else if (32'(pc) > MAX_PHASES) begin
      pc_eff = CW'(MAX_PHASES);
    end else begin
      pc_eff = CW'(pc);
    end
  end

  // elapsed time, saturating at the phase timer width
  assign delta    = awaiting ? '0 : (ts_q - prev);
  assign elap_sum = {{(TS_W + 1 - ELAP_W){1'b0}}, elapsed} + {1'b0, delta};

  // progress numerator
  assign capped = (elapsed > ELAP_W'(cur_act)) ? cur_act : elapsed[DUR_W-1:0];
  assign numer  = SW'(capped) + earlier;

  // duration error magnitude and sign
  assign err_neg = elapsed < ELAP_W'(cur_act);
  assign mag     = err_neg ? (ELAP_W'(cur_act) - elapsed) : (elapsed - ELAP_W'(cur_act));

  // saturating update of the next table entry
  assign scaled  = prod[MW-1:8];
  assign pos_sum = (DUR_W + 10)'(nxt_rd) + (DUR_W + 10)'(scaled);
  always_comb begin
    if (neg) begin
      corr_val = (scaled > (MW - 8)'(nxt_rd)) ? '0 : (nxt_rd - scaled[DUR_W-1:0]);
    end else begin
      corr_val = (pos_sum > (DUR_W + 10)'(16'hFFFF)) ? 16'hFFFF : pos_sum[DUR_W-1:0];
    end
  end

  assign act_inc = ((32'(active) + 1) == 32'(cnt_eff)) ? '0 : (active + 1'b1);

  assign sum_last  = (state == S_SUM) && (idx == cnt_eff) && !rd_v;
  assign div_start = sum_last && (total != '0);

  // table port selection
  always_comb begin
    cur_we = 1'b0;
    cur_wa = AW'(in_ch.data.load_index);
    cur_wd = in_ch.data.load_duration;
    nxt_we = 1'b0;
    nxt_wa = AW'(in_ch.data.load_index);
    nxt_wd = in_ch.data.load_duration;
    nxt_ra = active;
    if (load_ok) begin
      cur_we = 1'b1;
      nxt_we = 1'b1;
    end
    if (state == S_CORR) begin
      nxt_we = 1'b1;
      nxt_wa = active;
      nxt_wd = corr_val;
    end
    if (state == S_COPY) begin
      nxt_ra = idx[AW-1:0];
      cur_we = rd_v;
      cur_wa = rd_i;
      cur_wd = nxt_rd;
    end
  end

  appe_tbl #(.DEPTH(MAX_PHASES), .AW(AW)) u_cur (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cur_we),
    .wr_addr (cur_wa),
    .wr_data (cur_wd),
    .rd_addr (idx[AW-1:0]),
    .rd_data (cur_rd)
  );

  appe_tbl #(.DEPTH(MAX_PHASES), .AW(AW)) u_nxt (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (nxt_we),
    .wr_addr (nxt_wa),
    .wr_data (nxt_wd),
    .rd_addr (nxt_ra),
    .rd_data (nxt_rd)
  );

  appe_div #(.W(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (total),
    .quot  (quot),
    .st    (div_st)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lr <= LR_RESET;
      pc <= PC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARNING_RATE: lr <= cfg_data;
        CFG_PHASE_COUNT:   pc <= cfg_data[PC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      active   <= '0;
      elapsed  <= '0;
      prev     <= '0;
      awaiting <= 1'b1;
      rd_v     <= 1'b0;
      idx      <= '0;
      ovalid   <= 1'b0;
    end else begin
      // drop the taken result unless a new one moves in this cycle
      if (ovalid && out_ch.ready && (state != S_OUT)) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (in_ch.data.kind == KIND_SAMPLE)) begin
            ts_q    <= in_ch.data.timestamp_ms;
            adv_q   <= in_ch.data.advance_phase;
            cnt_eff <= pc_eff;
            if (32'(active) >= 32'(pc_eff)) begin
              active <= '0;
            end
            state <= S_TIME;
          end
        end
        S_TIME: begin
          elapsed  <= (elap_sum > (TS_W + 1)'(ELAP_MAX)) ? ELAP_MAX : elap_sum[ELAP_W-1:0];
          prev     <= ts_q;
          awaiting <= 1'b0;
          idx      <= '0;
          rd_v     <= 1'b0;
          total    <= '0;
          earlier  <= '0;
          cur_act  <= '0;
          state    <= S_SUM;
        end
        S_SUM: begin
          // accumulate the entry read last cycle, issue the next read
          if (rd_v) begin
            total <= total + SW'(cur_rd);
            if (rd_i < active) begin
              earlier <= earlier + SW'(cur_rd);
            end
            if (rd_i == active) begin
              cur_act <= cur_rd;
            end
          end
          rd_v <= idx < cnt_eff;
          rd_i <= idx[AW-1:0];
          if (idx < cnt_eff) begin
            idx <= idx + 1'b1;
          end
          if (sum_last) begin
            zero_q <= (total == '0);
            if (total == '0) begin
              prog  <= '0;
              state <= adv_q ? S_MUL : S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            prog  <= quot;
            state <= adv_q ? S_MUL : S_OUT;
          end
        end
        S_MUL: begin
          prod  <= MW'(mag) * MW'(lr);
          neg   <= err_neg;
          state <= S_CORR;
        end
        S_CORR: begin
          // next-table write happens through the port mux; advance the phase
          elapsed <= '0;
          active  <= act_inc;
          idx     <= '0;
          rd_v    <= 1'b0;
          state   <= (act_inc == '0) ? S_COPY : S_OUT;
        end
        S_COPY: begin
          rd_v <= 32'(idx) < MAX_PHASES;
          rd_i <= idx[AW-1:0];
          if (32'(idx) < MAX_PHASES) begin
            idx <= idx + 1'b1;
          end
          if ((32'(idx) == MAX_PHASES) && !rd_v) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid || out_ch.ready) begin
            odata.progress    <= prog;
            odata.phase_index <= IDX_W'(active);
            odata.advanced    <= adv_q;
            odata.total_zero  <= zero_q;
            ovalid            <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a zero total never yields a nonzero progress
  a_zero_prog: assert property (@(posedge clk) disable iff (rst)
    (ovalid && odata.total_zero) |-> (odata.progress == '0))
    else $error("progress nonzero with zero total");

  // progress never passes one whole cycle
  a_prog_max: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (odata.progress <= PROG_W'(65536)))
    else $error("progress above full scale");

  // the phase index stays inside the clamped count when a result is formed
  a_phase_rng: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (32'(active) < 32'(cnt_eff)))
    else $error("active phase outside phase count");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider result outside divide state");

endmodule

// File: sim/adaptive_phase_progress_estimator_tb.sv
// Testbench for the adaptive phase progress estimator: directed rows, then random
// samples and loads, checked against a cycle-free prediction of the duration tables.
// Depends on appe_pkg, appe_if and the adaptive_phase_progress_estimator top level.
module adaptive_phase_progress_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import appe_pkg::*;

  localparam int MAX_PHASES    = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam int CHUNKS        = 9;
  localparam int CHUNK_ITEMS   = 88;

  // register indexes past the two real registers; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    appe_in_t              item;
    bit                    typed;
    appe_out_t             res;
  } step_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  appe_in_if  in_ch ();
  appe_out_if out_ch ();

  adaptive_phase_progress_estimator #(
    .MAX_PHASES(MAX_PHASES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predicted block state
  logic [DUR_W-1:0]  cur_dur [MAX_PHASES];
  logic [DUR_W-1:0]  nxt_dur [MAX_PHASES];
  logic [IDX_W-1:0]  act_ph;
  logic [ELAP_W-1:0] ph_ms;
  logic [TS_W-1:0]   last_ts;
  logic              first_pending;
  logic [LR_W-1:0]   lr;
  logic [PC_W-1:0]   pc;

  appe_out_t progress_expected [$];
  step_t     directed_steps [$];
  int        err_count     = 0;
  int        send_idle_pct = 7;
  int        recv_idle_pct = 83;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int phase_limit(logic [PC_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_PHASES) return MAX_PHASES;
    return int'(n);
  endfunction

  // Advance the predicted state by one item; a sample yields one result.
  task automatic predict_item(input appe_in_t it, output bit has_res, output appe_out_t res);
    int                cnt;
    longint unsigned   sum_ms, before_ms, total_ms, prog;
    longint            err, mag, scaled, v;
    logic [TS_W-1:0]   delta;
    logic [DUR_W-1:0]  capped;
    res = '0;
    has_res = 1'b0;
    if (it.kind == KIND_LOAD) begin
      cur_dur[it.load_index] = it.load_duration;
      nxt_dur[it.load_index] = it.load_duration;
    end else begin
      cnt = phase_limit(pc);
      if (int'(act_ph) >= cnt) act_ph = '0;
      // first sample only sets the time base
      if (first_pending) begin
        last_ts = it.timestamp_ms;
        first_pending = 1'b0;
      end
      delta = it.timestamp_ms - last_ts;
      sum_ms = 64'(ph_ms) + 64'(delta);
      ph_ms = (sum_ms > 64'(ELAP_MAX)) ? ELAP_MAX : sum_ms[ELAP_W-1:0];
      last_ts = it.timestamp_ms;

      capped = (ph_ms > 24'(cur_dur[act_ph])) ? cur_dur[act_ph] : ph_ms[DUR_W-1:0];
      before_ms = 0;
      total_ms = 0;
      for (int i = 0; i < cnt; i++) begin
        if (i < int'(act_ph)) before_ms += 64'(cur_dur[i]);
        total_ms += 64'(cur_dur[i]);
      end
      res.total_zero = (total_ms == 0);
      if (total_ms != 0) begin
        prog = ((64'(capped) + before_ms) << 16) / total_ms;
        if (prog > 65536) prog = 65536;
        res.progress = prog[PROG_W-1:0];
      end

      // correct the learning table, then step the phase
      if (it.advance_phase) begin
        err = longint'(ph_ms) - longint'(cur_dur[act_ph]);
        mag = (err < 0) ? -err : err;
        scaled = (mag * longint'(lr)) >>> 8;
        v = longint'(nxt_dur[act_ph]) + ((err < 0) ? -scaled : scaled);
        if (v < 0) v = 0;
        else if (v > 65535) v = 65535;
        nxt_dur[act_ph] = v[DUR_W-1:0];
        ph_ms = '0;
        act_ph = IDX_W'((int'(act_ph) + 1) % cnt);
        if (act_ph == 0) begin
          foreach (cur_dur[i]) cur_dur[i] = nxt_dur[i];
        end
      end
      res.phase_index = act_ph;
      res.advanced = it.advance_phase;
      has_res = 1'b1;
    end
  endtask

  // Present one item at the falling edge and hold it until accepted.
  task automatic send_item(input appe_in_t it, input bit typed, input appe_out_t typed_res);
    appe_out_t res;
    bit        has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it, has_res, res);
    if (has_res) progress_expected.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Hold off the sender until every result is in and the block has settled.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (progress_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_LEARNING_RATE: lr = val[LR_W-1:0];
      CFG_PHASE_COUNT:   pc = val[PC_W-1:0];
      default: ;
    endcase
  endtask

  function automatic step_t sample_row(logic [TS_W-1:0] ts, logic adv, bit typed = 1'b0,
                                       appe_out_t res = '0);
    step_t s;
    s.is_cfg = 1'b0;
    s.reg_idx = CFG_LEARNING_RATE;
    s.reg_val = '0;
    s.item.kind = KIND_SAMPLE;
    s.item.timestamp_ms = ts;
    s.item.advance_phase = adv;
    s.item.load_index = IDX_W'($urandom);
    s.item.load_duration = DUR_W'($urandom);
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  function automatic step_t load_row(logic [IDX_W-1:0] idx, logic [DUR_W-1:0] dur);
    step_t s;
    s = sample_row(TS_W'($urandom), 1'b1);
    s.item.kind = KIND_LOAD;
    s.item.load_index = idx;
    s.item.load_duration = dur;
    return s;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = sample_row('0, 1'b0);
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Drop the result ready at random, per the current receiver idle rate.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    appe_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (progress_expected.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: expected none, got progress %0d phase %0d",
                 $time, out_ch.data.progress, out_ch.data.phase_index);
      end else begin
        want = progress_expected.pop_front();
        check_field("progress", 32'(want.progress), 32'(out_ch.data.progress));
        check_field("phase_index", 32'(want.phase_index), 32'(out_ch.data.phase_index));
        check_field("advanced", 32'(want.advanced), 32'(out_ch.data.advanced));
        check_field("total_zero", 32'(want.total_zero), 32'(out_ch.data.total_zero));
      end
    end
  end

  initial begin : stimulus
    appe_in_t              it;
    int                    r;
    int                    cnt;
    logic [CFG_DATA_W-1:0] val;
    logic [TS_W-1:0]       ts_now;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LEARNING_RATE;
    cfg_data = '0;
    foreach (cur_dur[i]) begin
      cur_dur[i] = '0;
      nxt_dur[i] = '0;
    end
    act_ph = '0;
    ph_ms = '0;
    last_ts = '0;
    first_pending = 1'b1;
    lr = LR_RESET;
    pc = PC_RESET;

    // Directed rows: empty tables, timestamp wrap, load extremes, saturation,
    // gain extremes, every kind of phase count and the spare register indexes.
    directed_steps.push_back(sample_row(32'hFFFF_FFF0, 1'b0, 1'b1,
      '{progress: '0, phase_index: 4'd0, advanced: 1'b0, total_zero: 1'b1}));
    directed_steps.push_back(sample_row(32'h0000_0010, 1'b1, 1'b1,
      '{progress: '0, phase_index: 4'd1, advanced: 1'b1, total_zero: 1'b1}));
    directed_steps.push_back(load_row(4'd0, 16'hFFFF));
    directed_steps.push_back(load_row(4'd1, 16'h0000));
    directed_steps.push_back(load_row(4'd2, 16'd1000));
    directed_steps.push_back(load_row(4'd3, 16'd2000));
    directed_steps.push_back(load_row(4'd15, 16'hFFFF));
    directed_steps.push_back(sample_row(32'h0000_0110, 1'b0));
    directed_steps.push_back(sample_row(32'h0000_000F, 1'b0));
    directed_steps.push_back(sample_row(32'hFFFF_FFFF, 1'b1));
    directed_steps.push_back(sample_row(32'h0000_0000, 1'b1));
    directed_steps.push_back(sample_row(32'h0000_1000, 1'b1));
    directed_steps.push_back(cfg_row(CFG_LEARNING_RATE, 9'd511));
    directed_steps.push_back(sample_row(32'h0000_2000, 1'b1));
    directed_steps.push_back(sample_row(32'h0000_2010, 1'b1));
    directed_steps.push_back(cfg_row(CFG_LEARNING_RATE, 9'd0));
    directed_steps.push_back(sample_row(32'h0000_2020, 1'b1));
    directed_steps.push_back(sample_row(32'h0000_2030, 1'b1));
    directed_steps.push_back(cfg_row(CFG_PHASE_COUNT, 9'd16));
    for (int k = 0; k < 5; k++)
      directed_steps.push_back(sample_row(32'h0000_3000 + 32'(k * 300), 1'b1));
    // lowered count leaves the active phase out of range
    directed_steps.push_back(cfg_row(CFG_PHASE_COUNT, 9'd2));
    directed_steps.push_back(sample_row(32'h0000_4000, 1'b0));
    directed_steps.push_back(cfg_row(CFG_PHASE_COUNT, 9'd0));
    directed_steps.push_back(sample_row(32'h0000_4100, 1'b1));
    directed_steps.push_back(cfg_row(CFG_PHASE_COUNT, 9'd31));
    directed_steps.push_back(sample_row(32'h0000_4200, 1'b0));
    directed_steps.push_back(cfg_row(CFG_SPARE_2, 9'h1FF));
    directed_steps.push_back(cfg_row(CFG_SPARE_3, 9'h0AA));
    directed_steps.push_back(sample_row(32'h0000_4300, 1'b1));
    // upper data bits set: the count field reads 17
    directed_steps.push_back(cfg_row(CFG_PHASE_COUNT, 9'h1F1));
    directed_steps.push_back(cfg_row(CFG_LEARNING_RATE, 9'd256));
    directed_steps.push_back(sample_row(32'h0000_4400, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_cfg) begin
        wait_idle();
        write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
      end else begin
        send_item(directed_steps[k].item, directed_steps[k].typed, directed_steps[k].res);
      end
    end

    // Random part: each chunk sets the gain and count, preloads the table,
    // then runs mostly steady samples with loads and noise mixed in.
    ts_now = last_ts;
    for (int c = 0; c < CHUNKS; c++) begin
      send_idle_pct = (c < 3) ? 7 : (c < 6) ? 83 : 0;
      recv_idle_pct = (c < 3) ? 83 : (c < 6) ? 7 : 0;
      wait_idle();

      r = $urandom_range(99);
      if (c == 0) val = 9'd0;
      else if (c == CHUNKS - 1) val = 9'd511;
      else if (r < 40) val = CFG_DATA_W'($urandom_range(511));
      else val = CFG_DATA_W'($urandom_range(16, 80));
      write_reg(CFG_LEARNING_RATE, val);

      r = $urandom_range(99);
      if (c == 2) val = 9'd16;
      else if (c == 5) val = 9'd1;
      else if (r < 10) val = 9'd0;
      else if (r < 20) val = CFG_DATA_W'($urandom_range(17, 31));
      else val = CFG_DATA_W'($urandom_range(2, 8));
      write_reg(CFG_PHASE_COUNT, val);
      if (c % 4 == 3) write_reg((c < 4) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));

      cnt = phase_limit(pc);
      for (int i = 0; i < cnt; i++) begin
        it = appe_in_t'({$urandom, $urandom});
        it.kind = KIND_LOAD;
        it.load_index = IDX_W'(i);
        it.load_duration = DUR_W'($urandom_range(200, 3000));
        send_item(it, 1'b0, '0);
      end

      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        it = appe_in_t'({$urandom, $urandom});
        r = $urandom_range(99);
        if (r < 8) begin
          it.kind = KIND_LOAD;
          if ($urandom_range(3) != 0) it.load_duration = DUR_W'($urandom_range(0, 4000));
        end else if (r < 12) begin
          // noise: arbitrary jump, forward or backward
          it.kind = KIND_SAMPLE;
          ts_now = it.timestamp_ms;
        end else begin
          it.kind = KIND_SAMPLE;
          ts_now = ts_now + TS_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2500));
          it.timestamp_ms = ts_now;
          it.advance_phase = ($urandom_range(99) < 35);
        end
        send_item(it, 1'b0, '0);
        if ($urandom_range(99) == 0) wait_idle();
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
